FILE: src/irc_line_tokenizer_core_assert.svh
// assertion macros used by the tokenizer checker
`ifndef IRC_LINE_TOKENIZER_CORE_ASSERT_SVH
`define IRC_LINE_TOKENIZER_CORE_ASSERT_SVH

// clocked assertion with reset disable and a fixed message
`define IRCLT_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("irclt assertion failed");

// clocked assertion with reset disable and a caller message
`define IRCLT_ASSERT_MSG(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`endif

FILE: src/irclt_pkg.sv
// types and constants of the line tokenizer
`timescale 1ns / 1ps

package irclt_pkg;

    // parse phases
    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_PREFIX  = 3'd1;
    localparam logic [2:0] PH_COMMAND = 3'd2;
    localparam logic [2:0] PH_PSTART  = 3'd3;
    localparam logic [2:0] PH_PARAM   = 3'd4;
    localparam logic [2:0] PH_TRAIL   = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    // byte kinds
    localparam logic [2:0] K_PREFIX  = 3'd0;
    localparam logic [2:0] K_COMMAND = 3'd1;
    localparam logic [2:0] K_PARAM   = 3'd2;
    localparam logic [2:0] K_TRAIL   = 3'd3;
    localparam logic [2:0] K_SEP     = 3'd4;
    localparam logic [2:0] K_DROP    = 3'd5;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // counter limits
    localparam logic [3:0] PARAM_SAT = 4'd15;
    localparam logic [2:0] CMD_SAT   = 3'd4;
    localparam logic [2:0] CMD_DROP  = 3'd3;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] cmd_pos;
        logic       all_digits;
        logic [3:0] cur_param;
        logic       ovf_seen;
    } parse_state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] param_index;
        logic       overflow;
    } tag_t;

    localparam parse_state_t STATE_RESET = '{
        phase:      PH_START,
        cmd_pos:    3'd0,
        all_digits: 1'b1,
        cur_param:  4'd0,
        ovf_seen:   1'b0
    };

endpackage

FILE: src/irclt_step.sv
// next-state and tag logic for one byte of a line
`timescale 1ns / 1ps

module irclt_step #(
    parameter int MAX_PARAMS = 15
) (
    input  irclt_pkg::parse_state_t st,
    input  logic [7:0]              data_byte,
    input  logic                    line_end,
    output irclt_pkg::parse_state_t st_next,
    output irclt_pkg::tag_t         tag
);

    localparam logic [3:0] PARAM_LIMIT = 4'(MAX_PARAMS);

    irclt_pkg::parse_state_t ns;
    logic [2:0] kind;
    logic [3:0] idx;
    logic       is_sep;
    logic       is_digit;
    logic       do_cmd;

    assign is_sep   = (data_byte == irclt_pkg::CH_SPACE) || (data_byte == irclt_pkg::CH_NL)
                   || (data_byte == irclt_pkg::CH_NUL);
    assign is_digit = (data_byte >= irclt_pkg::CH_ZERO) && (data_byte <= irclt_pkg::CH_NINE);

    always_comb begin
        ns     = st;
        kind   = irclt_pkg::K_DROP;
        idx    = 4'd0;
        do_cmd = 1'b0;

        unique case (st.phase)
            irclt_pkg::PH_START: begin
                if (data_byte == irclt_pkg::CH_COLON) begin
                    ns.phase = irclt_pkg::PH_PREFIX;
                    kind     = irclt_pkg::K_PREFIX;
                end else begin
                    do_cmd = 1'b1;
                end
            end
            irclt_pkg::PH_PREFIX: begin
                if (data_byte == irclt_pkg::CH_SPACE || data_byte == irclt_pkg::CH_NUL) begin
                    ns.phase = irclt_pkg::PH_COMMAND;
                    kind     = irclt_pkg::K_SEP;
                end else begin
                    kind = irclt_pkg::K_PREFIX;
                end
            end
            irclt_pkg::PH_COMMAND: begin
                do_cmd = 1'b1;
            end
            irclt_pkg::PH_PSTART: begin
                idx = st.cur_param;
                if (data_byte == irclt_pkg::CH_NUL) begin
                    kind     = irclt_pkg::K_SEP;
                    ns.phase = irclt_pkg::PH_DONE;
                end else if (st.cur_param >= PARAM_LIMIT) begin
                    ns.ovf_seen = 1'b1;
                    kind        = irclt_pkg::K_DROP;
                    ns.phase    = irclt_pkg::PH_DONE;
                end else if (data_byte == irclt_pkg::CH_COLON) begin
                    kind     = irclt_pkg::K_TRAIL;
                    ns.phase = irclt_pkg::PH_TRAIL;
                end else if (is_sep) begin
                    kind = irclt_pkg::K_SEP;
                    if (st.cur_param < irclt_pkg::PARAM_SAT) begin
                        ns.cur_param = st.cur_param + 4'd1;
                    end
                end else begin
                    kind     = irclt_pkg::K_PARAM;
                    ns.phase = irclt_pkg::PH_PARAM;
                end
            end
            irclt_pkg::PH_PARAM: begin
                idx = st.cur_param;
                if (is_sep) begin
                    kind     = irclt_pkg::K_SEP;
                    ns.phase = irclt_pkg::PH_PSTART;
                    if (st.cur_param < irclt_pkg::PARAM_SAT) begin
                        ns.cur_param = st.cur_param + 4'd1;
                    end
                end else begin
                    kind = irclt_pkg::K_PARAM;
                end
            end
            irclt_pkg::PH_TRAIL: begin
                idx  = st.cur_param;
                kind = irclt_pkg::K_TRAIL;
            end
            default: begin
                idx      = st.cur_param;
                kind     = irclt_pkg::K_DROP;
                ns.phase = irclt_pkg::PH_DONE;
            end
        endcase

        // command byte, shared by line start and command phase
        if (do_cmd) begin
            if (st.cmd_pos == irclt_pkg::CMD_DROP && st.all_digits) begin
                ns.phase = irclt_pkg::PH_PSTART;
                kind     = irclt_pkg::K_DROP;
            end else if (is_sep) begin
                ns.phase = irclt_pkg::PH_PSTART;
                kind     = irclt_pkg::K_SEP;
            end else begin
                ns.phase = irclt_pkg::PH_COMMAND;
                kind     = irclt_pkg::K_COMMAND;
                if (!is_digit) begin
                    ns.all_digits = 1'b0;
                end
                if (st.cmd_pos < irclt_pkg::CMD_SAT) begin
                    ns.cmd_pos = st.cmd_pos + 3'd1;
                end
            end
        end
    end

    assign tag.kind        = kind;
    assign tag.param_index = idx;
    assign tag.overflow    = ns.ovf_seen;
    assign st_next         = line_end ? irclt_pkg::STATE_RESET : ns;

endmodule

FILE: src/irc_line_tokenizer_core.sv
// top level of the message line tokenizer
`timescale 1ns / 1ps

// byte tagger for text-protocol message lines, one byte per transaction
// input channel s_*: tdata carries the raw byte, tlast marks the final byte
// of a line; parse state goes back to line start after that byte
// result channel m_*: one result transaction for every input transaction,
// in order; tdata holds the byte and its parameter index, tuser the kind
// code and the overflow flag, tlast copies the input tlast
// the result is registered: m_tvalid rises in the cycle after input acceptance
// throughput: one byte per cycle while the receiver keeps m_tready high; the bound
// is the parse state register, whose next value depends on the byte just taken
// the result sits in a single output register; s_tready is high whenever
// that register is empty or is being drained in the same cycle, so a
// stalled receiver holds the input back after at most one result
// reset: a synchronous aresetn low empties the output register and
// returns the parser to line start with no parameters and no overflow
module irc_line_tokenizer_core #(
    parameter int MAX_PARAMS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // line_end
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_out, [11:8] param_index, [15:12] zero
    output logic [3:0]  m_tuser,   // [2:0] kind, [3] overflow
    output logic        m_tlast    // last
);

    // parse state across bytes of a line
    irclt_pkg::parse_state_t state_reg;
    irclt_pkg::parse_state_t state_next;
    irclt_pkg::tag_t         tag;

    // output register
    logic       m_valid_reg;
    logic [7:0] byte_reg;
    logic [2:0] kind_reg;
    logic [3:0] idx_reg;
    logic       ovf_reg;
    logic       last_reg;

    logic s_accept;

    // free slot when empty or draining this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    irclt_step #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_step (
        .st        (state_reg),
        .data_byte (s_tdata),
        .line_end  (s_tlast),
        .st_next   (state_next),
        .tag       (tag)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= irclt_pkg::STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each accepted input
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byte_reg <= s_tdata;
            kind_reg <= tag.kind;
            idx_reg  <= tag.param_index;
            ovf_reg  <= tag.overflow;
            last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, idx_reg, byte_reg};
    assign m_tuser  = {ovf_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

FILE: src/irclt_checker.sv
// port-level checks for the line tokenizer, bound to the top level
`timescale 1ns / 1ps
`include "irc_line_tokenizer_core_assert.svh"

module irclt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result keeps its payload
    `IRCLT_ASSERT_MSG(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // input is only held back by a full, stalled output
    `IRCLT_ASSERT_MSG(a_ready, !s_tready |-> m_tvalid && !m_tready, "input stalled without cause")

    // overflow only shows on dropped bytes
    `IRCLT_ASSERT_MSG(a_ovf_drop, m_tvalid && m_tuser[3] |-> m_tuser[2:0] == irclt_pkg::K_DROP, "overflow on a kept byte")

    // prefix and command bytes carry parameter index zero
    `IRCLT_ASSERT(a_idx_zero, m_tvalid && (m_tuser[2:0] == irclt_pkg::K_PREFIX || m_tuser[2:0] == irclt_pkg::K_COMMAND) |-> m_tdata[11:8] == 4'd0)

endmodule

bind irc_line_tokenizer_core irclt_checker u_irclt_checker (.*);

FILE: verif/tb.sv
// testbench for the message line tokenizer, checked against a local parser
`timescale 1ns / 1ps

module tb;

    localparam int MAX_FIELDS = 15;

    // one tagged byte as the tokenizer should report it
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic [3:0] idx;
        logic       ovf;
        logic       last;
    } token_t;

    typedef logic [7:0] byte_q_t[$];

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // local copy of the parse state, advanced once per accepted byte
    irclt_pkg::parse_state_t parser;
    // tags still owed by the block, oldest first
    token_t       pending[$];
    // bytes of the line about to be sent
    byte_q_t      line_buf;

    bit send_idle;
    bit sink_idle;
    int stall_left;
    int errors;
    int bytes_sent;
    int lines_sent;
    int results_seen;
    int ovf_results;
    int kind_count[8];

    irc_line_tokenizer_core #(
        .MAX_PARAMS(MAX_FIELDS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------
    // parser model
    // ---------------------------------------------------------------

    // space, newline and nul split fields
    function automatic bit is_delim(input logic [7:0] b);
        return b == irclt_pkg::CH_SPACE || b == irclt_pkg::CH_NL || b == irclt_pkg::CH_NUL;
    endfunction

    // one command byte; a numeric command loses its fourth byte
    function automatic logic [2:0] command_kind(input logic [7:0] b);
        if (parser.cmd_pos == irclt_pkg::CMD_DROP && parser.all_digits) begin
            parser.phase = irclt_pkg::PH_PSTART;
            return irclt_pkg::K_DROP;
        end
        if (is_delim(b)) begin
            parser.phase = irclt_pkg::PH_PSTART;
            return irclt_pkg::K_SEP;
        end
        parser.phase = irclt_pkg::PH_COMMAND;
        if (b < irclt_pkg::CH_ZERO || b > irclt_pkg::CH_NINE)
            parser.all_digits = 1'b0;
        if (parser.cmd_pos < irclt_pkg::CMD_SAT)
            parser.cmd_pos = parser.cmd_pos + 3'd1;
        return irclt_pkg::K_COMMAND;
    endfunction

    function automatic void close_param();
        if (parser.cur_param < irclt_pkg::PARAM_SAT)
            parser.cur_param = parser.cur_param + 4'd1;
    endfunction

    // tag one accepted byte and advance the parse state
    function automatic token_t tag_byte(input logic [7:0] b, input logic eol);
        token_t t;
        t.data = b;
        t.kind = irclt_pkg::K_DROP;
        t.idx  = 4'd0;
        t.last = eol;
        case (parser.phase)
            irclt_pkg::PH_START: begin
                if (b == irclt_pkg::CH_COLON) begin
                    parser.phase = irclt_pkg::PH_PREFIX;
                    t.kind = irclt_pkg::K_PREFIX;
                end else begin
                    t.kind = command_kind(b);
                end
            end
            irclt_pkg::PH_PREFIX: begin
                // newline stays inside the prefix, nul closes it like a space
                if (b == irclt_pkg::CH_SPACE || b == irclt_pkg::CH_NUL) begin
                    parser.phase = irclt_pkg::PH_COMMAND;
                    t.kind = irclt_pkg::K_SEP;
                end else begin
                    t.kind = irclt_pkg::K_PREFIX;
                end
            end
            irclt_pkg::PH_COMMAND: t.kind = command_kind(b);
            irclt_pkg::PH_PSTART: begin
                t.idx = parser.cur_param;
                if (b == irclt_pkg::CH_NUL) begin
                    t.kind = irclt_pkg::K_SEP;
                    parser.phase = irclt_pkg::PH_DONE;
                end else if (parser.cur_param >= MAX_FIELDS) begin
                    parser.ovf_seen = 1'b1;
                    t.kind = irclt_pkg::K_DROP;
                    parser.phase = irclt_pkg::PH_DONE;
                end else if (b == irclt_pkg::CH_COLON) begin
                    t.kind = irclt_pkg::K_TRAIL;
                    parser.phase = irclt_pkg::PH_TRAIL;
                end else if (is_delim(b)) begin
                    // empty parameter
                    t.kind = irclt_pkg::K_SEP;
                    close_param();
                end else begin
                    t.kind = irclt_pkg::K_PARAM;
                    parser.phase = irclt_pkg::PH_PARAM;
                end
            end
            irclt_pkg::PH_PARAM: begin
                t.idx = parser.cur_param;
                if (is_delim(b)) begin
                    t.kind = irclt_pkg::K_SEP;
                    close_param();
                    parser.phase = irclt_pkg::PH_PSTART;
                end else begin
                    t.kind = irclt_pkg::K_PARAM;
                end
            end
            irclt_pkg::PH_TRAIL: begin
                t.idx = parser.cur_param;
                t.kind = irclt_pkg::K_TRAIL;
            end
            default: begin
                t.idx = parser.cur_param;
                t.kind = irclt_pkg::K_DROP;
                parser.phase = irclt_pkg::PH_DONE;
            end
        endcase
        t.ovf = parser.ovf_seen;
        if (eol)
            parser = irclt_pkg::STATE_RESET;
        return t;
    endfunction

    // ---------------------------------------------------------------
    // line builders
    // ---------------------------------------------------------------

    // any byte, weighted toward the ones the parser reacts to
    function automatic logic [7:0] pick_any();
        case ($urandom_range(0, 7))
            0: return irclt_pkg::CH_COLON;
            1: return irclt_pkg::CH_SPACE;
            2: return irclt_pkg::CH_NL;
            3: return irclt_pkg::CH_NUL;
            4: return irclt_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // a byte that cannot split a field
    function automatic logic [7:0] pick_text(input bit no_colon);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_delim(b) || (no_colon && b == irclt_pkg::CH_COLON));
        return b;
    endfunction

    function automatic logic [7:0] pick_sep();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return irclt_pkg::CH_SPACE;
        else if (r < 9)
            return irclt_pkg::CH_NL;
        return irclt_pkg::CH_NUL;
    endfunction

    // field body; first byte never a colon so it cannot open a trailing part
    function automatic void add_word(input int len);
        line_buf.push_back(pick_text(1'b1));
        repeat (len - 1) line_buf.push_back(pick_text(1'b0));
    endfunction

    // well formed line with random content: prefix, command, params, trailing
    function automatic void build_line();
        int n;
        line_buf = {};
        if ($urandom_range(0, 2) == 0) begin
            line_buf.push_back(irclt_pkg::CH_COLON);
            repeat ($urandom_range(0, 5))
                line_buf.push_back($urandom_range(0, 4) == 0 ?
                    irclt_pkg::CH_NL : pick_text(1'b0));
            line_buf.push_back($urandom_range(0, 5) == 0 ?
                irclt_pkg::CH_NUL : irclt_pkg::CH_SPACE);
        end
        case ($urandom_range(0, 3))
            0: begin
                // numeric reply code, fourth byte gets dropped
                repeat (3)
                    line_buf.push_back(irclt_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                line_buf.push_back($urandom_range(0, 1) ? irclt_pkg::CH_SPACE : pick_any());
            end
            1: begin
                add_word($urandom_range(1, 8));
                line_buf.push_back(pick_sep());
            end
            2: begin
                // mostly digits, to hit commands that only start numeric
                repeat ($urandom_range(1, 5))
                    line_buf.push_back($urandom_range(0, 2) != 0 ?
                        irclt_pkg::CH_ZERO + 8'($urandom_range(0, 9)) : pick_any());
                line_buf.push_back(pick_sep());
            end
            default: line_buf.push_back(pick_sep());
        endcase
        n = $urandom_range(0, 3) == 0 ? $urandom_range(12, 17) : $urandom_range(0, 5);
        repeat (n) begin
            if ($urandom_range(0, 7) != 0)
                add_word($urandom_range(1, 6));
            line_buf.push_back(pick_sep());
        end
        if ($urandom_range(0, 1)) begin
            line_buf.push_back(irclt_pkg::CH_COLON);
            repeat ($urandom_range(0, 8)) line_buf.push_back(pick_any());
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // one input transaction, expectation queued at acceptance
    task automatic push_byte(input logic [7:0] b, input logic eol);
        int gap;
        if (send_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom_range(0, 255));
                s_tlast  <= 1'($urandom_range(0, 1));
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending.push_back(tag_byte(b, eol));
        bytes_sent++;
    endtask

    // the whole line buffer, tlast on its final byte
    task automatic send_line();
        foreach (line_buf[i])
            push_byte(line_buf[i], i == line_buf.size() - 1);
        lines_sent++;
    endtask

    // short hand-built lines for each special case
    task automatic test_directed();
        send_idle = 1'b0;
        sink_idle = 1'b0;
        // prefix with newline inside, closed by nul, then a trailing part holding nul
        line_buf = {irclt_pkg::CH_COLON, 8'h61, irclt_pkg::CH_NL, irclt_pkg::CH_NUL, 8'h43,
                    irclt_pkg::CH_SPACE, irclt_pkg::CH_COLON, irclt_pkg::CH_NUL};
        send_line();
        // empty command, nul at parameter start, rest of line dropped
        line_buf = {irclt_pkg::CH_SPACE, irclt_pkg::CH_NUL, 8'hFF};
        send_line();
        // numeric command whose fourth byte is a nul
        line_buf = {irclt_pkg::CH_ZERO, irclt_pkg::CH_NINE, irclt_pkg::CH_ZERO,
                    irclt_pkg::CH_NUL};
        send_line();
        // params closed by newline, an empty one, and nul after a word
        line_buf = {8'h78, irclt_pkg::CH_SPACE, 8'hFF, irclt_pkg::CH_NL,
                    irclt_pkg::CH_SPACE, 8'h7F, irclt_pkg::CH_NUL};
        send_line();
    endtask

    // exactly fifteen params, then a nul or something that would open a sixteenth
    task automatic test_param_limit();
        send_idle = 1'b1;
        sink_idle = 1'b1;
        for (int i = 0; i < 8; i++) begin
            line_buf = {};
            add_word($urandom_range(1, 3));
            line_buf.push_back(irclt_pkg::CH_SPACE);
            repeat (MAX_FIELDS) begin
                if ($urandom_range(0, 3) != 0)
                    add_word($urandom_range(1, 3));
                line_buf.push_back($urandom_range(0, 3) == 0 ?
                    irclt_pkg::CH_NL : irclt_pkg::CH_SPACE);
            end
            case (i % 4)
                0: add_word($urandom_range(1, 4));
                1: line_buf.push_back(irclt_pkg::CH_NUL);
                2: line_buf.push_back(irclt_pkg::CH_COLON);
                default: line_buf.push_back(irclt_pkg::CH_SPACE);
            endcase
            repeat ($urandom_range(0, 3)) line_buf.push_back(pick_any());
            send_line();
        end
    endtask

    // mostly well formed lines, some raw noise, random stalls on both sides
    task automatic test_random_lines(input int upto);
        while (bytes_sent < upto) begin
            send_idle = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 7) == 0) begin
                line_buf = {};
                repeat ($urandom_range(1, 12)) line_buf.push_back(pick_any());
            end else begin
                build_line();
            end
            send_line();
        end
    endtask

    // back-to-back traffic with both sides always ready
    task automatic test_full_rate(input int upto);
        send_idle = 1'b0;
        sink_idle = 1'b0;
        while (bytes_sent < upto) begin
            build_line();
            send_line();
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // receiver stalls in random bursts while sink_idle is set
    always @(negedge aclk) begin
        if (!sink_idle) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    // each result transaction against the oldest expected tag
    always @(posedge aclk) begin : check_results
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending.pop_front();
                check_field("byte", 16'(want.data), 16'(m_tdata[7:0]));
                check_field("param_index", 16'(want.idx), 16'(m_tdata[11:8]));
                check_field("tdata pad", 16'd0, 16'(m_tdata[15:12]));
                check_field("kind", 16'(want.kind), 16'(m_tuser[2:0]));
                check_field("overflow", 16'(want.ovf), 16'(m_tuser[3]));
                check_field("last", 16'(want.last), 16'(m_tlast));
                results_seen++;
                kind_count[want.kind]++;
                if (want.ovf)
                    ovf_results++;
            end
        end
    end

    // ---------------------------------------------------------------
    // run
    // ---------------------------------------------------------------

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        send_idle  = 1'b0;
        sink_idle  = 1'b0;
        stall_left = 0;
        errors     = 0;
        parser     = irclt_pkg::STATE_RESET;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_param_limit();
        test_random_lines(1000);
        test_full_rate(1250);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        // drain the output register, plus margin for stray results
        repeat (4) @(posedge aclk);

        $display("covered %0d lines, %0d bytes, %0d results checked, %0d with overflow set",
                 lines_sent, bytes_sent, results_seen, ovf_results);
        $display("kinds seen: prefix %0d command %0d param %0d trailing %0d sep %0d dropped %0d",
                 kind_count[irclt_pkg::K_PREFIX], kind_count[irclt_pkg::K_COMMAND],
                 kind_count[irclt_pkg::K_PARAM], kind_count[irclt_pkg::K_TRAIL],
                 kind_count[irclt_pkg::K_SEP], kind_count[irclt_pkg::K_DROP]);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest stalled run
    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule
